// File: design/hsv_to_rgb_converter_unit_macros.svh
// Assertion macros shared by the checker of the HSV to RGB converter.
`ifndef HSV_TO_RGB_CONVERTER_UNIT_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_MACROS_SVH

// Antecedent at this edge implies consequent at the next edge, outside reset.
`define HSVC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hsv_to_rgb_converter_unit: next-cycle check failed");

// Antecedent implies consequent in the same cycle, outside reset.
`define HSVC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsv_to_rgb_converter_unit: same-cycle check failed");

// Next-cycle check that is also active while reset is applied.
`define HSVC_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("hsv_to_rgb_converter_unit: reset check failed");

`endif

// File: design/hsvc_pkg.sv
// Package with constants, stage payload types and arithmetic helpers of the converter.
`default_nettype none
package hsvc_pkg;

  localparam logic [8:0]  HUE_SECTOR_DEG = 9'd60;
  localparam logic [7:0]  LEVEL_MAX      = 8'd255;
  localparam logic [6:0]  PCT_MAX        = 7'd100;
  // Reciprocals: floor(x*M >> k) equals x/255 for x <= 65025 and x/100 for x <= 25500.
  localparam logic [31:0] DIV255_MUL     = 32'd32897;
  localparam logic [30:0] DIV100_MUL     = 31'd41944;

  // Hue sector codes; codes six to eight map as sector five.
  localparam logic [3:0] SEC_RED_YEL = 4'd0;
  localparam logic [3:0] SEC_YEL_GRN = 4'd1;
  localparam logic [3:0] SEC_GRN_CYN = 4'd2;
  localparam logic [3:0] SEC_CYN_BLU = 4'd3;
  localparam logic [3:0] SEC_BLU_MAG = 4'd4;

  typedef struct packed {
    logic [3:0] sector;
    logic [7:0] rem;
    logic [6:0] v;
    logic [7:0] sat;
  } s1_t;

  typedef struct packed {
    logic [3:0]  sector;
    logic [6:0]  v;
    logic [15:0] prod_q;
    logic [15:0] prod_t;
    logic [14:0] full_prod;
    logic [14:0] p_prod;
  } s2_t;

  typedef struct packed {
    logic [3:0]  sector;
    logic [6:0]  v;
    logic [7:0]  q_sub;
    logic [7:0]  t_sub;
    logic [14:0] full_prod;
    logic [14:0] p_prod;
  } s3_t;

  typedef struct packed {
    logic [3:0]  sector;
    logic [14:0] full_prod;
    logic [14:0] p_prod;
    logic [14:0] q_prod;
    logic [14:0] t_prod;
  } s4_t;

  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [31:0] m;
    m = 32'(x) * DIV255_MUL;
    return m[30:23];
  endfunction

  function automatic logic [7:0] div100(input logic [14:0] x);
    logic [30:0] m;
    m = 31'(x) * DIV100_MUL;
    return m[29:22];
  endfunction

endpackage
`default_nettype wire

// File: design/hsvc_sector.sv
// First stage: value clamp, hue sector search and in-sector position.
`default_nettype none
module hsvc_sector (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        up_valid,
  output logic             up_ready,
  input  wire logic [8:0]  hue_deg,
  input  wire logic [6:0]  value_pct,
  input  wire logic [7:0]  sat,
  output logic             dn_valid,
  input  wire logic        dn_ready,
  output hsvc_pkg::s1_t    dn_data
);

  logic          valid_r;
  hsvc_pkg::s1_t data_r, data_nxt;
  logic [3:0]    sector;
  logic [8:0]    base;
  logic [5:0]    pos;
  logic [9:0]    pos17;

  always_comb begin
    sector = 4'd0;
    base   = 9'd0;
    for (int k = 1; k <= 8; k++) begin
      if (hue_deg >= 9'(k) * hsvc_pkg::HUE_SECTOR_DEG) begin
        sector = 4'(k);
        base   = 9'(k) * hsvc_pkg::HUE_SECTOR_DEG;
      end
    end
    pos   = 6'(hue_deg - base);
    // pos*255/60 is pos*17/4.
    pos17 = {pos, 4'd0} + 10'(pos);
    data_nxt.sector = sector;
    data_nxt.rem    = pos17[9:2];
    data_nxt.v      = (value_pct > hsvc_pkg::PCT_MAX) ? hsvc_pkg::PCT_MAX : value_pct;
    data_nxt.sat    = sat;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule
`default_nettype wire

// File: design/hsvc_levels.sv
// Stages two to four: saturation products, division by 255 and value products.
`default_nettype none
module hsvc_levels (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        up_valid,
  output logic             up_ready,
  input  wire hsvc_pkg::s1_t up_data,
  output logic             dn_valid,
  input  wire logic        dn_ready,
  output hsvc_pkg::s4_t    dn_data
);

  logic          v2_r, v3_r, v4_r;
  logic          rdy2, rdy3, rdy4;
  hsvc_pkg::s2_t d2_r, d2_nxt;
  hsvc_pkg::s3_t d3_r, d3_nxt;
  hsvc_pkg::s4_t d4_r, d4_nxt;

  assign rdy4     = !v4_r || dn_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign up_ready = rdy2;

  always_comb begin
    d2_nxt.sector    = up_data.sector;
    d2_nxt.v         = up_data.v;
    d2_nxt.prod_q    = 16'(up_data.sat) * 16'(up_data.rem);
    d2_nxt.prod_t    = 16'(up_data.sat) * 16'(hsvc_pkg::LEVEL_MAX - up_data.rem);
    d2_nxt.full_prod = 15'(up_data.v) * 15'(hsvc_pkg::LEVEL_MAX);
    d2_nxt.p_prod    = 15'(up_data.v) * 15'(hsvc_pkg::LEVEL_MAX - up_data.sat);

    d3_nxt.sector    = d2_r.sector;
    d3_nxt.v         = d2_r.v;
    d3_nxt.q_sub     = hsvc_pkg::LEVEL_MAX - hsvc_pkg::div255(d2_r.prod_q);
    d3_nxt.t_sub     = hsvc_pkg::LEVEL_MAX - hsvc_pkg::div255(d2_r.prod_t);
    d3_nxt.full_prod = d2_r.full_prod;
    d3_nxt.p_prod    = d2_r.p_prod;

    d4_nxt.sector    = d3_r.sector;
    d4_nxt.full_prod = d3_r.full_prod;
    d4_nxt.p_prod    = d3_r.p_prod;
    d4_nxt.q_prod    = 15'(d3_r.v) * 15'(d3_r.q_sub);
    d4_nxt.t_prod    = 15'(d3_r.v) * 15'(d3_r.t_sub);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy2) v2_r <= up_valid;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
    if (rdy2 && up_valid) d2_r <= d2_nxt;
    if (rdy3 && v2_r)     d3_r <= d3_nxt;
    if (rdy4 && v3_r)     d4_r <= d4_nxt;
  end

  assign dn_valid = v4_r;
  assign dn_data  = d4_r;

endmodule
`default_nettype wire

// File: design/hsvc_mix.sv
// Last stage: division by 100, sector channel mapping and the output register.
`default_nettype none
module hsvc_mix (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        up_valid,
  output logic             up_ready,
  input  wire hsvc_pkg::s4_t up_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue
);

  logic       valid_r;
  logic [7:0] red_r, green_r, blue_r;
  logic [7:0] red_nxt, green_nxt, blue_nxt;
  logic [7:0] full, p, q, t;

  always_comb begin
    full = hsvc_pkg::div100(up_data.full_prod);
    p    = hsvc_pkg::div100(up_data.p_prod);
    q    = hsvc_pkg::div100(up_data.q_prod);
    t    = hsvc_pkg::div100(up_data.t_prod);
    case (up_data.sector)
      hsvc_pkg::SEC_RED_YEL: begin red_nxt = full; green_nxt = t;    blue_nxt = p;    end
      hsvc_pkg::SEC_YEL_GRN: begin red_nxt = q;    green_nxt = full; blue_nxt = p;    end
      hsvc_pkg::SEC_GRN_CYN: begin red_nxt = p;    green_nxt = full; blue_nxt = t;    end
      hsvc_pkg::SEC_CYN_BLU: begin red_nxt = p;    green_nxt = q;    blue_nxt = full; end
      hsvc_pkg::SEC_BLU_MAG: begin red_nxt = t;    green_nxt = p;    blue_nxt = full; end
      default:               begin red_nxt = full; green_nxt = p;    blue_nxt = q;    end
    endcase
  end

  assign up_ready = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (up_ready && up_valid) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_valid = valid_r;
  assign red       = red_r;
  assign green     = green_r;
  assign blue      = blue_r;

endmodule
`default_nettype wire

// File: design/hsv_to_rgb_converter_unit.sv
// An accepted input passes the sector, levels and mix stage registers in turn to the output.
// Throughput: one transaction per cycle while out_stall is low; every stage register has its own valid bit.
// The five-stage pipeline spreads its multiplies over stages two to five, two or four per stage.
// Reset (rst_n, synchronous, active low) empties the pipeline and sets saturation to 255.
// Configuration writes are always taken; they must only be issued while the pipeline is empty.
`default_nettype none
module hsv_to_rgb_converter_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_saturation,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [8:0] in_hue_deg,
  input  wire logic [6:0] in_value_pct,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue
);

  // The saturation register is sampled by the first stage for each transaction.
  logic [7:0] sat_r;

  logic          s1_valid, s1_ready, s4_valid, s4_ready, in_ready;
  hsvc_pkg::s1_t s1_data;
  hsvc_pkg::s4_t s4_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= hsvc_pkg::LEVEL_MAX;
    end else if (cfg_valid && cfg_ready) begin
      sat_r <= cfg_saturation;
    end
  end

  // Each stage accepts whenever it is empty or its successor is taking its contents,
  // so bubbles collapse and a finished result waiting at the output does not block
  // new transactions until the whole pipeline is full.
  assign in_stall = !in_ready;

  // Stage one: clamp value to one hundred, find the 60 degree sector and the
  // position within it scaled to 0..250.
  hsvc_sector u_sector (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_valid),
    .up_ready  (in_ready),
    .hue_deg   (in_hue_deg),
    .value_pct (in_value_pct),
    .sat       (sat_r),
    .dn_valid  (s1_valid),
    .dn_ready  (s1_ready),
    .dn_data   (s1_data)
  );

  // Stages two to four: the p, q and t levels before the final division by one hundred.
  // Zero saturation needs no special path: p, q and t all come out equal to full grey.
  hsvc_levels u_levels (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (s1_data),
    .dn_valid (s4_valid),
    .dn_ready (s4_ready),
    .dn_data  (s4_data)
  );

  // Stage five: scale to 0..255 and route the levels onto red, green and blue.
  // Hues of 360 and above fall into the last sector's mapping.
  hsvc_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (s4_valid),
    .up_ready  (s4_ready),
    .up_data   (s4_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red       (out_red),
    .green     (out_green),
    .blue      (out_blue)
  );

endmodule
`default_nettype wire

// File: design/hsvc_checker.sv
// Port-level checker of the converter and its bind to the top level.
`default_nettype none
`include "hsv_to_rgb_converter_unit_macros.svh"
module hsvc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_red,
  input wire logic [7:0] out_green,
  input wire logic [7:0] out_blue
);

  `HSVC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `HSVC_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable({out_red, out_green, out_blue}))
  `HSVC_ASSERT_NOW(a_empty_accepts, !out_valid, !in_stall)
  `HSVC_ASSERT_RST(a_reset_empty, !rst_n, !out_valid)

endmodule

bind hsv_to_rgb_converter_unit hsvc_checker u_hsvc_checker (.*);
`default_nettype wire
